/* hdl/assert_macros.svh */
// assert_macros.svh
// Assertion shorthands for the integer square root checker; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ISQRT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ISQRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/isqrt_pkg.sv */
// isqrt_pkg.sv
// Field widths shared by the integer square root pipeline and its checker.
// No dependencies.
package isqrt_pkg;

   // Beat field widths on the stream ports.
   localparam int RADICAND_W = 64;
   localparam int ROOT_W     = 32;

endpackage

/* hdl/integer_square_root_floor.sv */
// integer_square_root_floor.sv
// Floor square root of a 64-bit radicand as a row of root-bit cells.
// Depends on isqrt_pkg and isqrt_cell.
//
//   channel | dir | tdata fields (low bit up)   | beat
//   req_    | in  | radicand [63:0]             | one radicand
//   rsp_    | out | root [31:0]                 | one root
//
// The row has one registered cell per root bit; a new radicand
// enters every cycle while the result side takes beats.
// The whole row holds while a result waits with rsp_tready low.
// Synchronous reset clears the cell valid bits only; data is not cleared.
// Radicand bits at and above DATA_WIDTH are ignored.
module integer_square_root_floor #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [isqrt_pkg::RADICAND_W-1:0] req_tdata,  // [63:0] radicand
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [isqrt_pkg::ROOT_W-1:0]     rsp_tdata   // [31:0] root
);
   import isqrt_pkg::*;

   localparam int STEPS = (DATA_WIDTH + 1) / 2;

   logic                  advance;
   logic                  valid_chain [STEPS+1];
   logic [DATA_WIDTH-1:0] rem_chain   [STEPS+1];
   logic [DATA_WIDTH-1:0] acc_chain   [STEPS+1];

   // Move the row only when the last stage is empty or being drained.
   assign advance    = !valid_chain[STEPS] || rsp_tready;
   assign req_tready = advance;

   // Feed the row with the masked radicand and an empty root.
   assign valid_chain[0] = req_tvalid;
   assign rem_chain[0]   = req_tdata[DATA_WIDTH-1:0];
   assign acc_chain[0]   = '0;

   // Build one cell per root bit, trial bit falling two places per cell.
   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      isqrt_cell #(
         .W         (DATA_WIDTH),
         .TRIAL_POS (2 * (STEPS - 1 - k))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_chain[k]),
         .rem_in    (rem_chain[k]),
         .acc_in    (acc_chain[k]),
         .valid_out (valid_chain[k+1]),
         .rem_out   (rem_chain[k+1]),
         .acc_out   (acc_chain[k+1])
      );
   end

   // Present the finished root.
   assign rsp_tvalid = valid_chain[STEPS];
   assign rsp_tdata  = ROOT_W'(acc_chain[STEPS]);

endmodule

/* hdl/isqrt_cell.sv */
// isqrt_cell.sv
// One root-bit step of the restoring square root, with its stage registers.
// Depends on nothing outside this file.
module isqrt_cell #(
   parameter int W         = 64,
   parameter int TRIAL_POS = 62
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         valid_in,
   input  logic [W-1:0] rem_in,
   input  logic [W-1:0] acc_in,
   output logic         valid_out,
   output logic [W-1:0] rem_out,
   output logic [W-1:0] acc_out
);

   localparam logic [W-1:0] TRIAL = W'(1) << TRIAL_POS;

   logic [W-1:0] cand;
   logic         take;
   logic [W-1:0] rem_in_n;
   logic [W-1:0] acc_in_n;
   logic         valid_ff;
   logic [W-1:0] rem_ff;
   logic [W-1:0] acc_ff;

   // Try the trial bit against the remainder; keep it when it fits.
   always_comb begin
      cand     = acc_in | TRIAL;
      take     = (rem_in >= cand);
      rem_in_n = take ? (rem_in - cand) : rem_in;
      acc_in_n = (acc_in >> 1) | (take ? TRIAL : '0);
   end

   // Hold the stage valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Advance the partial remainder and root.
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in_n;
         acc_ff <= acc_in_n;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign acc_out   = acc_ff;

endmodule

/* hdl/isqrt_checker.sv */
// isqrt_checker.sv
// Port-level checks on the integer square root block, bound to the top level.
// Depends on isqrt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isqrt_checker #(
   parameter int DATA_WIDTH = 64
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [isqrt_pkg::RADICAND_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [isqrt_pkg::ROOT_W-1:0]     rsp_tdata
);
   import isqrt_pkg::*;

   localparam int HALF = (DATA_WIDTH + 1) / 2;

   logic [ROOT_W:0] root_wide;
   logic            req_seen;

   assign root_wide = {1'b0, rsp_tdata};
   assign req_seen  = req_tvalid || (req_tdata != '0);

   // A stalled result beat stays put.
   `ISQRT_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "rsp beat changed while stalled")

   // Input is taken exactly when the result side can move.
   `ISQRT_ASSERT(a_req_ready, clock, reset, (req_tready == (!rsp_tvalid || rsp_tready)), "req_tready does not follow the output stall")

   // The root never reaches past half the radicand width.
   `ISQRT_ASSERT(a_root_range, clock, reset, (rsp_tvalid && req_seen) |-> ((root_wide >> HALF) == '0) || !rsp_tvalid, "root exceeds half width")

   // No result beat right after reset.
   `ISQRT_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "result beat right after reset")

endmodule

bind integer_square_root_floor isqrt_checker #(.DATA_WIDTH(DATA_WIDTH)) u_isqrt_checker (.*);
